FILE: hdl/trd_pkg.sv
// Shared types and constants for the triangle rasterizer with depth test.
package trd_pkg;

  localparam int unsigned QW = 34;  // quotient width of the divider
  localparam int unsigned NW = 34;  // width of numerators and divisor

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Start and result of one division.
  typedef struct packed {
    logic          start;
    logic [NW-1:0] num;
    logic [NW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

endpackage

FILE: hdl/triangle_raster_depth_test.sv
// Top level of the triangle rasterizer with depth test.
//
// Input channel in_*: one beat is either a corner load or a step request.
// A load writes one of three corners and restarts the walk at the lower-left
// corner of the bounding box; it produces no output beat. A step visits the
// next pixel of the box (rows rising, columns rising, edges included) and
// produces one output beat with position, interpolated depth and texture
// coordinate, a write flag and a done flag.
// Steps: an idle step (no walk active) answers with a beat that holds only the
// done flag. An inside pixel runs its setup products on one shared multiplier,
// then for each of depth, u and v a multiply-accumulate over the three corners
// and a division on one shared divider, then, if on screen, a depth read,
// compare and output. Outside or degenerate pixels skip the multiply-accumulate
// and the divider. in_tready is low while an item is in work.
// Reset: the depth store is cleared to the most negative depth by a pass over
// every address after reset, during which in_tready stays low.
// Stall: the finished beat waits in the output register; the next item is
// accepted as soon as the output register is free.
module triangle_raster_depth_test
  import trd_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = 256,
  parameter int unsigned FB_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[0], vert_slot[2:1], vert_x[10:3], vert_y[18:11],
  // vert_depth[34:19], vert_u[44:35], vert_v[54:45], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pix_x[7:0], pix_y[15:8], pix_depth[31:16], tex_u[41:32], tex_v[51:42],
  // pix_write[52], walk_done[53], zero fill
  output logic [55:0] out_tdata
);

  localparam int unsigned SIZE = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned AW   = $clog2(SIZE);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SETUP0, S_SETUP1, S_SETUP2, S_SETUP3, S_SETUP4,
    S_CHECK, S_MAC, S_DIV, S_RD, S_CMP, S_OUT
  } state_t;

  state_t state_r;

  logic [7:0]  cx_r [3];
  logic [7:0]  cy_r [3];
  logic signed [15:0] cz_r [3];
  logic [9:0]  cu_r [3];
  logic [9:0]  cv_r [3];
  logic [7:0]  col_r, row_r;
  logic        active_r;

  logic [AW-1:0] clr_r;
  logic signed [NW-1:0] d_r, n1_r, n2_r;
  logic signed [NW-1:0] acc_r [3];
  logic [1:0]  k_r;      // corner index of multiply-accumulate
  logic [1:0]  j_r;      // sum index for divider
  logic signed [15:0] depth_r;
  logic [9:0]  tu_r, tv_r;
  logic        onscr_r;
  logic        write_r;
  logic        ovalid_r;
  logic [55:0] odata_r;

  // box
  logic [7:0] bx0, bx1, by0, by1;
  always_comb begin
    bx0 = cx_r[0]; bx1 = cx_r[0]; by0 = cy_r[0]; by1 = cy_r[0];
    for (int k = 1; k < 3; k++) begin
      if (cx_r[k] < bx0) bx0 = cx_r[k];
      if (cx_r[k] > bx1) bx1 = cx_r[k];
      if (cy_r[k] < by0) by0 = cy_r[k];
      if (cy_r[k] > by1) by1 = cy_r[k];
    end
  end

  // load path: box of the corners after this write
  logic [1:0] slot;
  logic [7:0] lx, ly, lbx0, lby0;
  assign slot = in_tdata[2:1];
  assign lx   = in_tdata[10:3];
  assign ly   = in_tdata[18:11];
  always_comb begin
    lbx0 = 8'hFF; lby0 = 8'hFF;
    for (int k = 0; k < 3; k++) begin
      if ((slot == 2'(k) ? lx : cx_r[k]) < lbx0) lbx0 = (slot == 2'(k)) ? lx : cx_r[k];
      if ((slot == 2'(k) ? ly : cy_r[k]) < lby0) lby0 = (slot == 2'(k)) ? ly : cy_r[k];
    end
  end

  // shared multiplier, operands chosen by state
  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic signed [9:0]  abx, aby, acx, acy, pax, pay;
  assign abx = 10'(cx_r[1]) - 10'(cx_r[0]);
  assign aby = 10'(cy_r[1]) - 10'(cy_r[0]);
  assign acx = 10'(cx_r[2]) - 10'(cx_r[0]);
  assign acy = 10'(cy_r[2]) - 10'(cy_r[0]);
  assign pax = 10'(cx_r[0]) - 10'(col_r);
  assign pay = 10'(cy_r[0]) - 10'(row_r);

  logic signed [NW-1:0] nk;
  always_comb begin
    unique case (k_r)
      2'd1:    nk = n1_r;
      2'd2:    nk = n2_r;
      default: nk = d_r - n1_r - n2_r;
    endcase
  end

  always_comb begin
    ma = '0; mb = '0;
    unique case (state_r)
      S_SETUP0: begin ma = 18'(abx); mb = 18'(acy); end
      S_SETUP1: begin ma = 18'(acx); mb = 18'(aby); end
      S_SETUP2: begin ma = 18'(acx); mb = 18'(pay); end
      S_SETUP3: begin ma = 18'(acy); mb = 18'(pax); end
      S_SETUP4: begin ma = 18'(aby); mb = 18'(pax); end
      S_CHECK:  begin ma = 18'(abx); mb = 18'(pay); end
      S_MAC: begin
        ma = 18'(nk);
        unique case (j_r)
          2'd0:    mb = 18'(cz_r[k_r]);
          2'd1:    mb = {8'd0, cu_r[k_r]};
          default: mb = {8'd0, cv_r[k_r]};
        endcase
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;

  // divider: divide the magnitude of the full sum, restore the sign after
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [NW-1:0] sum_c;
  logic     neg;
  assign sum_c = acc_r[j_r] + NW'(prod);
  assign neg   = sum_c[NW-1];
  always_comb begin
    dreq.start = (state_r == S_MAC) && (k_r == 2'd2);
    dreq.num   = neg ? -sum_c : sum_c;
    dreq.den   = d_r;
  end
  // sign of the full sum for the division in flight
  logic       qneg_r;

  trd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // depth store
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] idx;
  assign idx = AW'(col_r) + AW'(32'(row_r) * FB_WIDTH);
  assign ram_we    = (state_r == S_CLEAR) ||
                     (state_r == S_CMP && depth_r > $signed(ram_rdata));
  assign ram_addr  = (state_r == S_CLEAR) ? clr_r : idx;
  assign ram_wdata = (state_r == S_CLEAR) ? 16'h8000 : depth_r;

  trd_ram #(.WIDTH(16), .DEPTH(SIZE)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic in_fire;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;
  logic last_c;
  assign last_c = (col_r >= bx1) && (row_r >= by1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      active_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      ovalid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        cx_r[k] <= '0; cy_r[k] <= '0; cz_r[k] <= '0; cu_r[k] <= '0; cv_r[k] <= '0;
      end
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(SIZE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_fire) begin
          if (in_tdata[0] == REQ_LOAD) begin
            if (slot != 2'd3) begin
              cx_r[slot] <= lx;
              cy_r[slot] <= ly;
              cz_r[slot] <= in_tdata[34:19];
              cu_r[slot] <= in_tdata[44:35];
              cv_r[slot] <= in_tdata[54:45];
              col_r      <= lbx0;
              row_r      <= lby0;
              active_r   <= 1'b1;
            end
          end else if (!active_r) begin
            odata_r  <= 56'd1 << 53;
            ovalid_r <= 1'b1;
          end else begin
            state_r <= S_SETUP0;
          end
        end
        S_SETUP0: begin d_r <= NW'(prod); state_r <= S_SETUP1; end
        S_SETUP1: begin d_r <= d_r - NW'(prod); state_r <= S_SETUP2; end
        S_SETUP2: begin n1_r <= NW'(prod); state_r <= S_SETUP3; end
        S_SETUP3: begin n1_r <= n1_r - NW'(prod); state_r <= S_SETUP4; end
        S_SETUP4: begin n2_r <= NW'(prod); state_r <= S_CHECK; end
        S_CHECK: begin
          // normalize to a positive area and test the weights
          logic signed [NW-1:0] n2v, n0v;
          n2v = n2_r - NW'(prod);
          n0v = d_r - n1_r - n2v;
          if (d_r < 0) begin
            d_r <= -d_r; n1_r <= -n1_r; n2_r <= -n2v;
          end else begin
            n2_r <= n2v;
          end
          onscr_r <= (32'(col_r) < FB_WIDTH) && (32'(row_r) < FB_HEIGHT);
          write_r <= 1'b0;
          depth_r <= '0; tu_r <= '0; tv_r <= '0;
          k_r <= '0; j_r <= '0;
          for (int k = 0; k < 3; k++) acc_r[k] <= '0;
          state_r <= ((d_r != 0) && ((d_r < 0) ?
                     (n0v <= 0 && n1_r <= 0 && n2v <= 0) :
                     (n0v >= 0 && n1_r >= 0 && n2v >= 0))) ? S_MAC : S_OUT;
        end
        S_MAC: begin
          acc_r[j_r] <= sum_c;
          if (k_r == 2'd2) begin
            k_r     <= '0;
            qneg_r  <= neg;
            state_r <= S_DIV;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DIV: if (drsp.done) begin
          unique case (j_r)
            2'd0:    depth_r <= qneg_r ? -16'(drsp.quo) : 16'(drsp.quo);
            2'd1:    tu_r <= 10'(drsp.quo);
            default: tv_r <= 10'(drsp.quo);
          endcase
          if (j_r == 2'd2) begin
            state_r <= onscr_r ? S_RD : S_OUT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          write_r <= depth_r > $signed(ram_rdata);
          state_r <= S_OUT;
        end
        S_OUT: begin
          odata_r <= {2'b0, last_c, write_r, tv_r, tu_r, depth_r, row_r, col_r};
          ovalid_r <= 1'b1;
          if (last_c) active_r <= 1'b0;
          else if (col_r >= bx1) begin col_r <= bx0; row_r <= row_r + 1'b1; end
          else col_r <= col_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

FILE: hdl/trd_ram.sv
// Generic single port RAM with registered read.
module trd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/trd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module trd_div
  import trd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NW-1]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[NW]) begin
        rem_nxt = trial[NW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[NW-2:0], quo_r[NW-1]};
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: dv/triangle_raster_depth_test_test.sv
// Testbench for the triangle rasterizer with depth test, with a scoreboard check.
`timescale 1ns / 100ps

class raster_scoreboard;
  bit [7:0]  cx [3];
  bit [7:0]  cy [3];
  bit [15:0] cz [3];
  bit [9:0]  cu [3];
  bit [9:0]  cv [3];
  bit [7:0]  col, row;
  bit        active;
  bit [15:0] zbuf [65536];
  bit [55:0] pixel_q [$];
  int        errors;

  function new();
    for (int i = 0; i < 3; i++) begin
      cx[i] = 0; cy[i] = 0; cz[i] = 0; cu[i] = 0; cv[i] = 0;
    end
    col = 0; row = 0; active = 0; errors = 0;
    foreach (zbuf[i]) zbuf[i] = 16'h8000;
  endfunction

  function void box(output int x0, output int y0, output int x1, output int y1);
    x0 = cx[0]; x1 = cx[0]; y0 = cy[0]; y1 = cy[0];
    for (int k = 1; k < 3; k++) begin
      if (cx[k] < x0) x0 = cx[k];
      if (cx[k] > x1) x1 = cx[k];
      if (cy[k] < y0) y0 = cy[k];
      if (cy[k] > y1) y1 = cy[k];
    end
  endfunction

  // Note one accepted input beat and queue the pixel it causes, if any.
  function void note_input(bit [55:0] d);
    int x0, y0, x1, y1, px, py, s;
    longint abx, aby, acx, acy, pax, pay, dd, n0, n1, n2, zs, us, vs;
    int depth;
    int tu, tv;
    bit wr, last;
    bit [55:0] r;
    depth = 0; tu = 0; tv = 0; wr = 0;
    if (d[0] == trd_pkg::REQ_LOAD) begin
      s = d[2:1];
      if (s > 2) return;
      cx[s] = d[10:3]; cy[s] = d[18:11]; cz[s] = d[34:19];
      cu[s] = d[44:35]; cv[s] = d[54:45];
      box(x0, y0, x1, y1);
      col = x0; row = y0; active = 1;
      return;
    end
    if (!active) begin
      r = '0; r[53] = 1'b1;
      pixel_q.push_back(r);
      return;
    end
    box(x0, y0, x1, y1);
    px = col; py = row;
    abx = longint'(cx[1]) - cx[0]; aby = longint'(cy[1]) - cy[0];
    acx = longint'(cx[2]) - cx[0]; acy = longint'(cy[2]) - cy[0];
    pax = longint'(cx[0]) - px;    pay = longint'(cy[0]) - py;
    dd = abx * acy - acx * aby;
    n1 = acx * pay - acy * pax;
    n2 = aby * pax - abx * pay;
    n0 = dd - n1 - n2;
    if (dd < 0) begin
      dd = -dd; n0 = -n0; n1 = -n1; n2 = -n2;
    end
    if (dd != 0 && n0 >= 0 && n1 >= 0 && n2 >= 0) begin
      zs = n0 * longint'($signed(cz[0])) + n1 * longint'($signed(cz[1]))
         + n2 * longint'($signed(cz[2]));
      us = n0 * cu[0] + n1 * cu[1] + n2 * cu[2];
      vs = n0 * cv[0] + n1 * cv[1] + n2 * cv[2];
      depth = int'(zs / dd); tu = int'(us / dd); tv = int'(vs / dd);
      if (depth > int'($signed(zbuf[px + 256 * py]))) begin
        zbuf[px + 256 * py] = depth[15:0];
        wr = 1;
      end
    end
    last = (px >= x1 && py >= y1);
    if (last) active = 0;
    else if (px >= x1) begin
      col = x0; row = py + 1;
    end else col = px + 1;
    r = '0;
    r[7:0] = px; r[15:8] = py; r[31:16] = depth[15:0];
    r[41:32] = tu[9:0]; r[51:42] = tv[9:0]; r[52] = wr; r[53] = last;
    pixel_q.push_back(r);
  endfunction

  function void check_pixel(bit [55:0] a);
    bit [55:0] e;
    if (pixel_q.size() == 0) begin
      $error("unexpected output beat %h", a);
      errors++;
      return;
    end
    e = pixel_q.pop_front();
    if (a[7:0] != e[7:0]) begin
      $error("pix_x exp %0d got %0d", e[7:0], a[7:0]); errors++;
    end
    if (a[15:8] != e[15:8]) begin
      $error("pix_y exp %0d got %0d", e[15:8], a[15:8]); errors++;
    end
    if (a[31:16] != e[31:16]) begin
      $error("pix_depth exp %0d got %0d", $signed(e[31:16]), $signed(a[31:16])); errors++;
    end
    if (a[41:32] != e[41:32]) begin
      $error("tex_u exp %0d got %0d", e[41:32], a[41:32]); errors++;
    end
    if (a[51:42] != e[51:42]) begin
      $error("tex_v exp %0d got %0d", e[51:42], a[51:42]); errors++;
    end
    if (a[52] != e[52]) begin
      $error("pix_write exp %0d got %0d", e[52], a[52]); errors++;
    end
    if (a[53] != e[53]) begin
      $error("walk_done exp %0d got %0d", e[53], a[53]); errors++;
    end
  endfunction
endclass

module triangle_raster_depth_test_test;
  import trd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // req_type, vert_slot, vert_x, vert_y, vert_depth, vert_u, vert_v, zero fill
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // pix_x, pix_y, pix_depth, tex_u, tex_v, pix_write, walk_done, zero fill
  logic [55:0] out_tdata;

  raster_scoreboard sb;
  int  idle_pct;       // chance of an idle cycle on either side
  bit  hold_out;       // receiver holds off while set
  int  quiet_cycles;   // cycles since the last beat on either side

  triangle_raster_depth_test dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Send one beat, with a random gap first; advance when accepted.
  task automatic send_beat(bit [55:0] d);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_tdata  = d;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(d);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic load_corner(int s, int x, int y, int z, int u, int v);
    bit [55:0] d;
    d = '0;
    d[0] = REQ_LOAD; d[2:1] = s; d[10:3] = x; d[18:11] = y;
    d[34:19] = z; d[44:35] = u; d[54:45] = v;
    send_beat(d);
  endtask

  task automatic step_walk();
    bit [55:0] d;
    d = '0;
    d[0] = REQ_STEP;
    d[55:1] = {$urandom, $urandom};  // junk in unused fields of a step
    d[55] = 1'b0;
    send_beat(d);
  endtask

  // Step until the walk ends, capped so a big box cannot run away.
  task automatic walk_out(int cap);
    int n;
    n = 0;
    while (sb.active && n < cap) begin
      step_walk();
      n++;
    end
  endtask

  task automatic drain();
    while (sb.pixel_q.size() != 0) @(posedge clk);
  endtask

  // Random small triangle near a random origin; sometimes degenerate.
  task automatic random_triangle(int span);
    int ox, oy, x, y;
    ox = $urandom_range(255); oy = $urandom_range(255);
    for (int s = 0; s < 3; s++) begin
      x = ox + $urandom_range(span); y = oy + $urandom_range(span);
      if (x > 255) x = 255;
      if (y > 255) y = 255;
      load_corner(s, x, y, int'($urandom_range(32768)) - 16384,
                  $urandom_range(1023), $urandom_range(1023));
    end
  endtask

  // Receiver: random stalls, plus a held-off stretch on request.
  always @(negedge clk) begin
    if (!rst_n || hold_out) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: the reset clearing pass and a held-off receiver are well below this.
  initial begin
    wait (quiet_cycles >= 200000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    hold_out = 0; idle_pct = 37; quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle step, bad slot, extremes, degenerate, rewalk.
    step_walk();
    load_corner(3, 255, 255, 16384, 1023, 1023);
    step_walk();
    load_corner(0, 0, 0, -16384, 0, 0);
    load_corner(1, 3, 0, 16384, 1023, 0);
    load_corner(2, 0, 3, 0, 0, 1023);
    walk_out(20);
    step_walk();
    load_corner(0, 1, 1, 100, 5, 5);   // reload one corner and walk again
    walk_out(20);
    load_corner(0, 255, 255, 16384, 1023, 1023);
    load_corner(1, 253, 255, 16384, 1023, 1023);
    load_corner(2, 255, 253, 16384, 1023, 1023);
    walk_out(10);
    load_corner(2, 254, 255, 0, 0, 0); // collinear
    walk_out(5);
    drain();

    // Long stretch with no idling.
    idle_pct = 0;
    for (int t = 0; t < 15; t++) begin
      random_triangle(4);
      walk_out(25);
    end
    idle_pct = 37;

    // Receiver holds off while the sender keeps offering.
    fork
      begin
        hold_out = 1;
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
      begin
        random_triangle(3);
        walk_out(10);
      end
    join
    drain();

    // Random part: mostly triangles walked out, some noise and early reloads.
    for (int t = 0; t < 150; t++) begin
      case ($urandom_range(9))
        0: load_corner($urandom_range(3), $urandom_range(255), $urandom_range(255),
                       int'($urandom_range(65535)) - 32768,
                       $urandom_range(1023), $urandom_range(1023));
        1: step_walk();
        2: begin
          random_triangle(5);
          walk_out($urandom_range(6));
        end
        default: begin
          random_triangle($urandom_range(1, 4));
          walk_out(30);
        end
      endcase
      if ($urandom_range(15) == 0) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: triangle_raster_depth_test.f
hdl/trd_pkg.sv
hdl/trd_ram.sv
hdl/trd_div.sv
hdl/triangle_raster_depth_test.sv
dv/triangle_raster_depth_test_test.sv
